// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL files that check themselves.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/bale_pkg.sv =====
// Types and constants of the bounded array list engine.
// Used by the channel interfaces and the top level; depends on nothing.
`default_nettype none

package bale_pkg;

	localparam int MODE_W = 3;
	localparam int POS_W  = 6;
	localparam int VAL_W  = 32;
	localparam int STAT_W = 2;
	localparam int LEN_W  = 7;

	typedef enum logic [MODE_W-1:0] {
		MODE_APPEND    = 3'd0,
		MODE_INSERT    = 3'd1,
		MODE_READ      = 3'd2,
		MODE_SEARCH    = 3'd3,
		MODE_OVERWRITE = 3'd4,
		MODE_DELETE    = 3'd5
	} mode_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK       = 2'd0,
		STAT_FULL     = 2'd1,
		STAT_RANGE    = 2'd2,
		STAT_NOTFOUND = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_SRCH,
		ST_INS,
		ST_INS_PUT,
		ST_DEL,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bale_req_if.sv =====
// Request channel of the bounded array list engine: valid/ready plus payload.
// Depends on bale_pkg for field widths.
`default_nettype none

interface bale_req_if import bale_pkg::*; ();

	logic                    valid;
	logic                    ready;
	logic [MODE_W-1:0]       mode;
	logic [POS_W-1:0]        position;
	logic signed [VAL_W-1:0] value;

	modport source (output valid, output mode, output position, output value, input ready);
	modport sink   (input valid, input mode, input position, input value, output ready);

endinterface

`default_nettype wire

// ===== hw/rtl/bale_rsp_if.sv =====
// Response channel of the bounded array list engine: valid/ready plus payload.
// Depends on bale_pkg for field widths.
`default_nettype none

interface bale_rsp_if import bale_pkg::*; ();

	logic                    valid;
	logic                    ready;
	logic [STAT_W-1:0]       status;
	logic [POS_W-1:0]        found_position;
	logic signed [VAL_W-1:0] read_value;
	logic [LEN_W-1:0]        length;

	modport source (output valid, output status, output found_position, output read_value,
		output length, input ready);
	modport sink   (input valid, input status, input found_position, input read_value,
		input length, output ready);

endinterface

`default_nettype wire

// ===== hw/rtl/bale_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module bale_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ===== hw/rtl/bounded_array_list_engine.sv =====
// Bounded array list engine: top level with sequencer and entry RAM.
// Depends on bale_pkg, bale_req_if, bale_rsp_if, bale_ram and assert_macros.svh.
//
// A dense list of up to CAPACITY signed 32-bit words kept in one RAM with a
// single write and a single registered read port; each request beat gives
// exactly one response beat with status and the length after the request.
// One request is worked at a time; ready is high only between requests, and
// a finished response waits in an output register without blocking the next
// request. Each request first passes the execute state; append, overwrite,
// unused modes and refused requests go on to the done state, read passes the
// read state, search walks to the first match or the list end, insert shifts
// then puts, delete shifts; done loads the response once the output is free.
// The walks of insert, delete and search move one entry per cycle through the
// RAM's single read port. The RAM is not cleared after reset.
`default_nettype none
`include "assert_macros.svh"

module bounded_array_list_engine import bale_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	bale_req_if.sink   req,
	bale_rsp_if.source rsp
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = (CW > POS_W) ? CW : POS_W;

	state_t state_q, state_d;

	logic [CW-1:0]           count_q;
	logic [CW-1:0]           idx_q;
	logic                    iss_q;
	logic                    vld_s1;
	logic [AW-1:0]           addr_s1;
	mode_t                   mode_q;
	logic [POS_W-1:0]        pos_q;
	logic signed [VAL_W-1:0] val_q;
	status_t                 res_status_q;
	logic [POS_W-1:0]        res_found_q;
	logic [VAL_W-1:0]        res_rdval_q;
	logic                    rsp_valid_q;
	status_t                 out_status_q;
	logic [POS_W-1:0]        out_found_q;
	logic [VAL_W-1:0]        out_rdval_q;
	logic [LEN_W-1:0]        out_len_q;

	logic          mem_we;
	logic [AW-1:0] mem_wr_addr;
	logic [VAL_W-1:0] mem_wr_data;
	logic [AW-1:0] mem_rd_addr;
	logic [VAL_W-1:0] mem_rd_data;

	logic full;
	logic pos_ok;
	logic issue_up;
	logic hit;
	logic at_pos;
	logic rsp_free;

	assign full     = (count_q == CW'(CAPACITY));
	assign pos_ok   = (XW'(pos_q) < XW'(count_q));
	assign issue_up = (idx_q < count_q);
	assign hit      = vld_s1 && (mem_rd_data == val_q);
	assign at_pos   = (XW'(idx_q) == XW'(pos_q));
	assign rsp_free = !rsp_valid_q || rsp.ready;

	bale_ram #(
		.WIDTH(VAL_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk    (clk),
		.we     (mem_we),
		.wr_addr(mem_wr_addr),
		.wr_data(mem_wr_data),
		.rd_addr(mem_rd_addr),
		.rd_data(mem_rd_data)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				case (mode_q)
					MODE_INSERT:    state_d = (full || !pos_ok) ? ST_DONE : ST_INS;
					MODE_READ:      state_d = pos_ok ? ST_READ : ST_DONE;
					MODE_SEARCH:    state_d = ST_SRCH;
					MODE_DELETE:    state_d = pos_ok ? ST_DEL : ST_DONE;
					default:        state_d = ST_DONE;
				endcase
			end
			ST_READ:    state_d = ST_DONE;
			ST_SRCH: begin
				if (hit || !issue_up) begin
					state_d = ST_DONE;
				end
			end
			ST_INS: begin
				if (!iss_q) begin
					state_d = ST_INS_PUT;
				end
			end
			ST_INS_PUT: state_d = ST_DONE;
			ST_DEL: begin
				if (!issue_up) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (rsp_free) begin
					state_d = ST_IDLE;
				end
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		mem_we      = 1'b0;
		mem_wr_addr = addr_s1;
		mem_wr_data = mem_rd_data;
		mem_rd_addr = idx_q[AW-1:0];
		case (state_q)
			ST_EXEC: begin
				mem_rd_addr = AW'(pos_q);
				mem_wr_data = val_q;
				if (mode_q == MODE_APPEND && !full) begin
					mem_we      = 1'b1;
					mem_wr_addr = count_q[AW-1:0];
				end else if (mode_q == MODE_OVERWRITE && pos_ok) begin
					mem_we      = 1'b1;
					mem_wr_addr = AW'(pos_q);
				end
			end
			ST_INS, ST_DEL: begin
				mem_we = vld_s1;
			end
			ST_INS_PUT: begin
				mem_we      = 1'b1;
				mem_wr_addr = AW'(pos_q);
				mem_wr_data = val_q;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	assign req.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			iss_q       <= 1'b0;
			vld_s1      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_EXEC: begin
					vld_s1 <= 1'b0;
					iss_q  <= 1'b1;
					if (mode_q == MODE_APPEND && !full) begin
						count_q <= count_q + CW'(1);
					end
				end
				ST_INS: begin
					vld_s1 <= iss_q;
					if (iss_q && at_pos) begin
						iss_q <= 1'b0;
					end
				end
				ST_SRCH: begin
					vld_s1 <= issue_up;
				end
				ST_DEL: begin
					vld_s1 <= issue_up;
					if (!issue_up) begin
						count_q <= count_q - CW'(1);
					end
				end
				ST_INS_PUT: begin
					count_q <= count_q + CW'(1);
				end
				default: begin
					vld_s1 <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					mode_q       <= mode_t'(req.mode);
					pos_q        <= req.position;
					val_q        <= req.value;
					res_status_q <= STAT_OK;
					res_found_q  <= '0;
					res_rdval_q  <= '0;
				end
			end
			ST_EXEC: begin
				case (mode_q)
					MODE_APPEND: begin
						if (full) begin
							res_status_q <= STAT_FULL;
						end
					end
					MODE_INSERT: begin
						idx_q <= count_q - CW'(1);
						if (full) begin
							res_status_q <= STAT_FULL;
						end else if (!pos_ok) begin
							res_status_q <= STAT_RANGE;
						end
					end
					MODE_SEARCH: begin
						idx_q        <= '0;
						res_status_q <= STAT_NOTFOUND;
					end
					MODE_DELETE: begin
						idx_q <= CW'(pos_q) + CW'(1);
						if (!pos_ok) begin
							res_status_q <= STAT_RANGE;
						end
					end
					MODE_READ, MODE_OVERWRITE: begin
						if (!pos_ok) begin
							res_status_q <= STAT_RANGE;
						end
					end
					default: begin
						res_status_q <= STAT_OK;
					end
				endcase
			end
			ST_READ: begin
				res_rdval_q <= mem_rd_data;
			end
			ST_INS: begin
				addr_s1 <= AW'(idx_q + CW'(1));
				if (iss_q && !at_pos) begin
					idx_q <= idx_q - CW'(1);
				end
			end
			ST_SRCH: begin
				addr_s1 <= idx_q[AW-1:0];
				if (issue_up) begin
					idx_q <= idx_q + CW'(1);
				end
				if (hit) begin
					res_status_q <= STAT_OK;
					res_found_q  <= POS_W'(addr_s1);
				end
			end
			ST_DEL: begin
				addr_s1 <= AW'(idx_q - CW'(1));
				if (issue_up) begin
					idx_q <= idx_q + CW'(1);
				end
			end
			ST_DONE: begin
				if (rsp_free) begin
					out_status_q <= res_status_q;
					out_found_q  <= res_found_q;
					out_rdval_q  <= res_rdval_q;
					out_len_q    <= LEN_W'(count_q);
				end
			end
			default: begin
				res_rdval_q <= res_rdval_q;
			end
		endcase
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.status         = out_status_q;
	assign rsp.found_position = out_found_q;
	assign rsp.read_value     = out_rdval_q;
	assign rsp.length         = out_len_q;

	`ASSERT_IMPL(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(CAPACITY),
		"entry count above capacity")
	`ASSERT_IMPL(a_ins_wr_bound, clk, arst_n, (state_q == ST_INS) && mem_we,
		CW'(mem_wr_addr) <= count_q, "insert shift writes past the list end")
	`ASSERT_NEXT(a_ins_count_hold, clk, arst_n, state_q == ST_INS,
		count_q == $past(count_q), "count moved during insert shift")
	`ASSERT_IMPL(a_rsp_from_done, clk, arst_n, $rose(rsp_valid_q),
		$past(state_q == ST_DONE), "response raised outside completion")

endmodule

`default_nettype wire
